/* rtl/bounded_array_list_engine_defines.svh */
// assertion macros for the bounded array list engine
// used by the top level; expects clk and rst in the including scope
`ifndef BOUNDED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, held off during reset
`define BALE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define BALE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bale_pkg.sv */
// shared types and codes for the bounded array list engine
// no dependencies; imported by the controller, the datapath and the top level
`default_nettype none

package bale_pkg;

  localparam int OP_W     = 2;
  localparam int MODE_W   = 2;
  localparam int INDEX_W  = 7;
  localparam int ELEM_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int CAP_W    = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // position modes
  localparam logic [MODE_W-1:0] MODE_AT    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LAST  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

  // what a decoded request actually does to the store
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [MODE_W-1:0]  position_mode;
    logic [INDEX_W-1:0] index;
    logic [ELEM_W-1:0]  element;
  } req_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ELEM_W-1:0]   read_data;
    logic [COUNT_W-1:0]  count;
    logic                is_full;
    logic                is_empty;
  } rsp_item_t;

  // controller to datapath, one strobe per cycle at most
  typedef struct packed {
    logic load_item;
    logic decide;
    logic ins_prime;
    logic ins_shift;
    logic ins_put;
    logic rem_prime;
    logic rem_shift;
    logic rd_issue;
    logic finish;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] dec_kind;
    logic       ptr_eq_pos;
    logic       ptrm1_eq_pos;
    logic       ptrp1_lt_count;
    logic       ptrp2_lt_count;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/bale_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module bale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/bale_datapath.sv */
// datapath: request register, count and capacity, decode of status,
// shift pointer and the entry ram; depends on bale_pkg and bale_ram
`default_nettype none

module bale_datapath import bale_pkg::*; #(
  parameter int DEPTH         = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  req_item_t        req_data,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  input  ctl_cmd_t         ctl,
  output dp_status_t       stat,
  output rsp_item_t        rsp_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int BW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int XW = BW + 1;
  localparam int SW = ELEMENT_WIDTH;
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

  logic [CAP_W-1:0] cap;
  logic [CW-1:0]    count;
  req_item_t        item;
  logic [STATUS_W-1:0] status_q;
  logic [1:0]       kind_q;
  logic [CW-1:0]    pos;
  logic [CW-1:0]    ptr;

  logic [XW-1:0] idx_x, count_x, cap_x, eff_cap_x, count_m1_x;
  logic [XW-1:0] dec_pos, rd_pos, ptr_p1_x, ptr_p2_x, count_after_x;
  logic [CW-1:0] ptr_m1, ptr_m2, count_after;
  logic          full_now;
  logic [STATUS_W-1:0] dec_status;
  logic [1:0]    dec_kind;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [SW-1:0] ram_wdata, ram_rdata, elem_w;
  logic [63:0]   elem64, rd64;

  assign idx_x      = XW'(item.index);
  assign count_x    = XW'(count);
  assign cap_x      = XW'(cap);
  assign eff_cap_x  = (cap_x > DEPTH_X) ? DEPTH_X : cap_x;
  assign count_m1_x = count_x - XW'(1);
  assign full_now   = count_x >= eff_cap_x;

  // status checks in the documented order
  always_comb begin
    dec_status = ST_INVALID;
    dec_kind   = KIND_NONE;
    dec_pos    = '0;
    rd_pos     = idx_x;
    case (item.position_mode)
      MODE_FIRST: rd_pos = '0;
      MODE_LAST:  rd_pos = count_m1_x;
      default:    rd_pos = idx_x;
    endcase
    case (item.operation)
      OP_INSERT: begin
        case (item.position_mode)
          MODE_AT: begin
            if (idx_x > count_x) begin
              dec_status = ST_INVALID;
            end else if (full_now) begin
              dec_status = ST_FULL;
            end else begin
              dec_status = ST_OK;
              dec_kind   = KIND_INSERT;
              dec_pos    = idx_x;
            end
          end
          MODE_FIRST, MODE_LAST: begin
            if (full_now) begin
              dec_status = ST_FULL;
            end else begin
              dec_status = ST_OK;
              dec_kind   = KIND_INSERT;
              dec_pos    = (item.position_mode == MODE_FIRST) ? '0 : count_x;
            end
          end
          default: dec_status = ST_INVALID;
        endcase
      end
      OP_REMOVE: begin
        case (item.position_mode)
          MODE_AT: begin
            if (idx_x >= count_x) begin
              dec_status = ST_INVALID;
            end else begin
              dec_status = ST_OK;
              dec_kind   = KIND_REMOVE;
              dec_pos    = idx_x;
            end
          end
          MODE_FIRST, MODE_LAST: begin
            if (count_x == '0) begin
              dec_status = ST_EMPTY;
            end else begin
              dec_status = ST_OK;
              dec_kind   = KIND_REMOVE;
              dec_pos    = (item.position_mode == MODE_FIRST) ? '0 : count_m1_x;
            end
          end
          default: dec_status = ST_INVALID;
        endcase
      end
      OP_READ: begin
        if (item.position_mode inside {MODE_AT, MODE_FIRST, MODE_LAST} &&
            count_x != '0 && rd_pos < count_x) begin
          dec_status = ST_OK;
          dec_kind   = KIND_READ;
          dec_pos    = rd_pos;
        end
      end
      default: dec_status = ST_INVALID;
    endcase
  end

  // shift pointer neighbors
  assign ptr_m1   = ptr - CW'(1);
  assign ptr_m2   = ptr - CW'(2);
  assign ptr_p1_x = XW'(ptr) + XW'(1);
  assign ptr_p2_x = XW'(ptr) + XW'(2);

  assign stat.dec_kind       = dec_kind;
  assign stat.ptr_eq_pos     = ptr == pos;
  assign stat.ptrm1_eq_pos   = ptr_m1 == pos;
  assign stat.ptrp1_lt_count = ptr_p1_x < count_x;
  assign stat.ptrp2_lt_count = ptr_p2_x < count_x;

  // element into store width, store word back to 32 bits
  always_comb begin
    elem64 = 64'(item.element);
    elem_w = elem64[SW-1:0];
    rd64 = '0;
    rd64[SW-1:0] = ram_rdata;
  end

  always_comb begin
    ram_raddr = pos[AW-1:0];
    if (ctl.ins_prime) begin
      ram_raddr = ptr_m1[AW-1:0];
    end else if (ctl.ins_shift) begin
      ram_raddr = ptr_m2[AW-1:0];
    end else if (ctl.rem_prime) begin
      ram_raddr = ptr_p1_x[AW-1:0];
    end else if (ctl.rem_shift) begin
      ram_raddr = ptr_p2_x[AW-1:0];
    end
  end

  assign ram_re    = ctl.ins_prime | ctl.ins_shift | ctl.rem_prime | ctl.rem_shift |
                     ctl.rd_issue;
  assign ram_we    = ctl.ins_shift | ctl.rem_shift | ctl.ins_put;
  assign ram_waddr = ctl.ins_put ? pos[AW-1:0] : ptr[AW-1:0];
  assign ram_wdata = ctl.ins_put ? elem_w : ram_rdata;

  bale_ram #(
    .WIDTH(SW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    case (kind_q)
      KIND_INSERT: count_after = count + CW'(1);
      KIND_REMOVE: count_after = count - CW'(1);
      default:     count_after = count;
    endcase
  end
  assign count_after_x = XW'(count_after);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cap   <= CAP_RESET;
      count <= '0;
    end else begin
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
      if (ctl.finish) begin
        count <= count_after;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item <= req_data;
    end
    if (ctl.decide) begin
      status_q <= dec_status;
      kind_q   <= dec_kind;
      pos      <= dec_pos[CW-1:0];
      ptr      <= (dec_kind == KIND_INSERT) ? count : dec_pos[CW-1:0];
    end else if (ctl.ins_shift) begin
      ptr <= ptr_m1;
    end else if (ctl.rem_shift) begin
      ptr <= ptr_p1_x[CW-1:0];
    end
    if (ctl.finish) begin
      rsp_data.status    <= status_q;
      rsp_data.read_data <= (kind_q == KIND_READ) ? rd64[ELEM_W-1:0] : '0;
      rsp_data.count     <= COUNT_W'(count_after);
      rsp_data.is_full   <= count_after_x >= eff_cap_x;
      rsp_data.is_empty  <= count_after == '0;
    end
  end

endmodule

`default_nettype wire

/* rtl/bale_ctrl.sv */
// controller: sequences decode, entry moves, reads and the result beat
// depends on bale_pkg
`default_nettype none

module bale_ctrl import bale_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  input  dp_status_t stat,
  output ctl_cmd_t   ctl
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECIDE    = 4'd1;
  localparam logic [3:0] S_INS_PRIME = 4'd2;
  localparam logic [3:0] S_INS_SHIFT = 4'd3;
  localparam logic [3:0] S_INS_PUT   = 4'd4;
  localparam logic [3:0] S_REM_PRIME = 4'd5;
  localparam logic [3:0] S_REM_SHIFT = 4'd6;
  localparam logic [3:0] S_RD_ISSUE  = 4'd7;
  localparam logic [3:0] S_FINISH    = 4'd8;

  logic [3:0] state, state_next;
  logic       rsp_valid_next;

  assign req_stall = state != S_IDLE;

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctl.load_item = 1'b1;
          state_next    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        ctl.decide = 1'b1;
        case (stat.dec_kind)
          KIND_INSERT: state_next = S_INS_PRIME;
          KIND_REMOVE: state_next = S_REM_PRIME;
          KIND_READ:   state_next = S_RD_ISSUE;
          default:     state_next = S_FINISH;
        endcase
      end
      S_INS_PRIME: begin
        if (stat.ptr_eq_pos) begin
          state_next = S_INS_PUT;
        end else begin
          ctl.ins_prime = 1'b1;
          state_next    = S_INS_SHIFT;
        end
      end
      S_INS_SHIFT: begin
        ctl.ins_shift = 1'b1;
        if (stat.ptrm1_eq_pos) begin
          state_next = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        ctl.ins_put = 1'b1;
        state_next  = S_FINISH;
      end
      S_REM_PRIME: begin
        if (stat.ptrp1_lt_count) begin
          ctl.rem_prime = 1'b1;
          state_next    = S_REM_SHIFT;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_REM_SHIFT: begin
        ctl.rem_shift = 1'b1;
        if (!stat.ptrp2_lt_count) begin
          state_next = S_FINISH;
        end
      end
      S_RD_ISSUE: begin
        ctl.rd_issue = 1'b1;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
    if (ctl.finish) begin
      rsp_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/bounded_array_list_engine.sv */
// top level of the bounded array list engine: controller plus datapath
// depends on bale_pkg, bale_ctrl, bale_datapath, bale_ram and the defines header
//
//   channel   beat          handshake             direction
//   req       req_item_t    req_valid / req_stall into the block
//   rsp       rsp_item_t    rsp_valid / rsp_stall out of the block
//   cfg       capacity      cfg_we (no stall)     into the block
//
// an insert or a remove shifts the entries past its position one word at a time before the result beat
// the entry ram moves one word per cycle (one read port, one write port, registered read)
// reset: entry count goes to zero and capacity to 64; the store is not cleared
// a new request beat is taken while the previous result beat still waits on rsp_stall
`default_nettype none
`include "bounded_array_list_engine_defines.svh"

module bounded_array_list_engine import bale_pkg::*; #(
  parameter int DEPTH         = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  // configuration: capacity limit
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  // request channel
  input  logic             req_valid,
  output logic             req_stall,
  input  req_item_t        req_data,
  // result channel
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_item_t        rsp_data
);

  ctl_cmd_t   ctl_cmd;
  dp_status_t dp_stat;

  // sequencer: decode, shift loop, read, result handoff
  bale_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (dp_stat),
    .ctl       (ctl_cmd)
  );

  // storage, count, capacity and status decode
  bale_datapath #(
    .DEPTH         (DEPTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl_cmd),
    .stat      (dp_stat),
    .rsp_data  (rsp_data)
  );

  // an accepted request is decoded in the very next cycle
  `BALE_ASSERT_NEXT(a_accept_then_decide, req_valid && !req_stall, ctl_cmd.decide, "accepted request not decoded")

  // the output register is never overwritten while its beat is stalled
  `BALE_ASSERT_SAME(a_no_overwrite, ctl_cmd.finish, !(rsp_valid && rsp_stall), "result overwritten while stalled")

  // while open for requests no entry move or result load is in flight
  `BALE_ASSERT_SAME(a_idle_quiet, !req_stall, !(ctl_cmd.ins_shift || ctl_cmd.rem_shift || ctl_cmd.finish), "work in flight while accepting")

  // a full status leaves the list full unless the capacity is raised while the request is in flight
  `BALE_ASSERT_SAME(a_full_flag, rsp_valid && rsp_data.status == ST_FULL, rsp_data.is_full, "full status without full flag")

endmodule

`default_nettype wire
